// ===== hw/rtl/cfdf_pkg.sv =====
// Package for the CRC-16 framed packet deframer.
// Holds the event codes, frame constants, result item type and CRC byte update.
// No dependencies; used by every module of the block.
`default_nettype none

package cfdf_pkg;

  // Counter width; the counter fields of a result item carry the same width
  localparam int CNT_W = 32;

  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] MAX_LEN_RST = 16'd512;

  localparam logic [7:0] CH_S   = 8'h53;  // 'S'
  localparam logic [7:0] CH_G   = 8'h47;  // 'G'
  localparam logic [7:0] CH_P   = 8'h50;  // 'P'
  localparam logic [7:0] CH_A   = 8'h41;  // 'A'
  localparam logic [7:0] CH_E   = 8'h45;  // 'E'
  localparam logic [7:0] CH_C   = 8'h43;  // 'C'
  localparam logic [7:0] CH_T   = 8'h54;  // 'T'
  localparam logic [7:0] CH_K   = 8'h4B;  // 'K'
  localparam logic [7:0] CH_B   = 8'h42;  // 'B'
  localparam logic [7:0] VER_ID = 8'h01;

  // Event codes of a result item
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_HEADER   = 3'd1,
    EV_DATA     = 3'd2,
    EV_VALID    = 3'd3,
    EV_CRC_FAIL = 3'd4,
    EV_RESYNC   = 3'd5
  } event_t;

  // One result item
  typedef struct packed {
    event_t           event_res;
    logic [7:0]       data_byte;
    logic [7:0]       frame_type;
    logic [15:0]      frame_length;
    logic [15:0]      payload_index;
    logic [15:0]      computed_crc;
    logic [15:0]      received_crc;
    logic [CNT_W-1:0] completed_frames;
    logic [CNT_W-1:0] valid_frames;
    logic [CNT_W-1:0] crc_failures;
    logic [CNT_W-1:0] recoveries;
  } res_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Accepted frame type letters
  function automatic logic type_ok(input logic [7:0] b);
    return (b == CH_S) || (b == CH_P) || (b == CH_A) || (b == CH_E) ||
           (b == CH_C) || (b == CH_T) || (b == CH_K) || (b == CH_B);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cfdf_parser.sv =====
// Frame parser: phase machine, running CRC, frame registers and counters.
// Builds one result item per accepted byte. Depends on cfdf_pkg.
`default_nettype none

module cfdf_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata,
  output cfdf_pkg::res_t     res
);

  typedef enum logic [3:0] {
    PH_MAGIC_S = 4'd0,
    PH_MAGIC_G = 4'd1,
    PH_VERSION = 4'd2,
    PH_TYPE    = 4'd3,
    PH_LEN_HI  = 4'd4,
    PH_LEN_LO  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CRC_HI  = 4'd7,
    PH_CRC_LO  = 4'd8
  } phase_t;

  phase_t                     phase_r, phase_nxt, phase_pre;
  logic [15:0]                crc_r, crc_nxt, crc_pre, crc_upd;
  logic [7:0]                 type_r, type_nxt, type_pre;
  logic [15:0]                len_r, len_nxt, len_pre, len_full;
  logic [15:0]                rcvd_r, rcvd_nxt, rcvd_pre, rcvd_inc;
  logic [15:0]                rxcrc_r, rxcrc_nxt, rxcrc_pre, rxcrc_full;
  logic [15:0]                max_len_r;
  logic [cfdf_pkg::CNT_W-1:0] done_cnt_r, done_cnt_nxt;
  logic [cfdf_pkg::CNT_W-1:0] good_cnt_r, good_cnt_nxt;
  logic [cfdf_pkg::CNT_W-1:0] fail_cnt_r, fail_cnt_nxt;
  logic [cfdf_pkg::CNT_W-1:0] rec_cnt_r, rec_cnt_nxt;
  cfdf_pkg::event_t           ev;
  logic [15:0]                idx, rcrc;
  logic                       do_resync, count_rec;

  assign crc_upd    = cfdf_pkg::crc_byte(crc_r, rx_byte);
  assign len_full   = {len_r[15:8], rx_byte};
  assign rcvd_inc   = rcvd_r + 16'd1;
  assign rxcrc_full = {rxcrc_r[15:8], rx_byte};

  // Per-byte phase decode
  always_comb begin
    phase_pre    = phase_r;
    crc_pre      = crc_r;
    type_pre     = type_r;
    len_pre      = len_r;
    rcvd_pre     = rcvd_r;
    rxcrc_pre    = rxcrc_r;
    done_cnt_nxt = done_cnt_r;
    good_cnt_nxt = good_cnt_r;
    fail_cnt_nxt = fail_cnt_r;
    ev           = cfdf_pkg::EV_NONE;
    idx          = 16'd0;
    rcrc         = 16'd0;
    do_resync    = 1'b0;
    count_rec    = 1'b0;
    case (phase_r)
      PH_MAGIC_S: begin
        if (rx_byte == cfdf_pkg::CH_S) phase_pre = PH_MAGIC_G;
      end
      PH_MAGIC_G: begin
        if (rx_byte == cfdf_pkg::CH_G) begin
          phase_pre = PH_VERSION;
        end else if (rx_byte != cfdf_pkg::CH_S) begin
          phase_pre = PH_MAGIC_S;
        end
      end
      PH_VERSION: begin
        if (rx_byte != cfdf_pkg::VER_ID) begin
          ev        = cfdf_pkg::EV_RESYNC;
          do_resync = 1'b1;
          count_rec = 1'b1;
        end else begin
          crc_pre   = crc_upd;
          phase_pre = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (!cfdf_pkg::type_ok(rx_byte)) begin
          ev        = cfdf_pkg::EV_RESYNC;
          do_resync = 1'b1;
          count_rec = 1'b1;
        end else begin
          type_pre  = rx_byte;
          crc_pre   = crc_upd;
          phase_pre = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_pre   = {rx_byte, 8'h00};
        crc_pre   = crc_upd;
        phase_pre = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        // low byte is folded in even when the length is too large
        len_pre = len_full;
        crc_pre = crc_upd;
        if (len_full > max_len_r) begin
          ev        = cfdf_pkg::EV_RESYNC;
          do_resync = 1'b1;
          count_rec = 1'b1;
        end else begin
          ev        = cfdf_pkg::EV_HEADER;
          phase_pre = (len_full == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        ev       = cfdf_pkg::EV_DATA;
        idx      = rcvd_r;
        crc_pre  = crc_upd;
        rcvd_pre = rcvd_inc;
        if (rcvd_inc == len_r) phase_pre = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        rxcrc_pre = {rx_byte, 8'h00};
        phase_pre = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        rxcrc_pre    = rxcrc_full;
        rcrc         = rxcrc_full;
        done_cnt_nxt = done_cnt_r + 1'b1;
        do_resync    = 1'b1;
        if (rxcrc_full == crc_r) begin
          good_cnt_nxt = good_cnt_r + 1'b1;
          ev           = cfdf_pkg::EV_VALID;
        end else begin
          fail_cnt_nxt = fail_cnt_r + 1'b1;
          ev           = cfdf_pkg::EV_CRC_FAIL;
          count_rec    = 1'b1;
        end
      end
      default: begin
        phase_pre = PH_MAGIC_S;
      end
    endcase
  end

  // Resync clears the frame registers and reloads the CRC
  always_comb begin
    rec_cnt_nxt = count_rec ? rec_cnt_r + 1'b1 : rec_cnt_r;
    if (do_resync) begin
      phase_nxt = (rx_byte == cfdf_pkg::CH_S) ? PH_MAGIC_G : PH_MAGIC_S;
      crc_nxt   = cfdf_pkg::CRC_INIT;
      type_nxt  = 8'd0;
      len_nxt   = 16'd0;
      rcvd_nxt  = 16'd0;
      rxcrc_nxt = 16'd0;
    end else begin
      phase_nxt = phase_pre;
      crc_nxt   = crc_pre;
      type_nxt  = type_pre;
      len_nxt   = len_pre;
      rcvd_nxt  = rcvd_pre;
      rxcrc_nxt = rxcrc_pre;
    end
  end

  // Result item: frame values before the resync, counters after the byte
  always_comb begin
    res.event_res        = ev;
    res.data_byte        = rx_byte;
    res.frame_type       = type_pre;
    res.frame_length     = len_pre;
    res.payload_index    = idx;
    res.computed_crc     = crc_pre;
    res.received_crc     = rcrc;
    res.completed_frames = done_cnt_nxt;
    res.valid_frames     = good_cnt_nxt;
    res.crc_failures     = fail_cnt_nxt;
    res.recoveries       = rec_cnt_nxt;
  end

  // State and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_MAGIC_S;
      crc_r      <= cfdf_pkg::CRC_INIT;
      type_r     <= 8'd0;
      len_r      <= 16'd0;
      rcvd_r     <= 16'd0;
      rxcrc_r    <= 16'd0;
      done_cnt_r <= '0;
      good_cnt_r <= '0;
      fail_cnt_r <= '0;
      rec_cnt_r  <= '0;
      max_len_r  <= cfdf_pkg::MAX_LEN_RST;
    end else begin
      if (cfg_we) max_len_r <= cfg_wdata;
      if (accept) begin
        phase_r    <= phase_nxt;
        crc_r      <= crc_nxt;
        type_r     <= type_nxt;
        len_r      <= len_nxt;
        rcvd_r     <= rcvd_nxt;
        rxcrc_r    <= rxcrc_nxt;
        done_cnt_r <= done_cnt_nxt;
        good_cnt_r <= good_cnt_nxt;
        fail_cnt_r <= fail_cnt_nxt;
        rec_cnt_r  <= rec_cnt_nxt;
      end
    end
  end

  // The last CRC byte always returns to magic hunting
  a_crc_lo_resync: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (phase_r == PH_CRC_LO) |=> (phase_r == PH_MAGIC_S) || (phase_r == PH_MAGIC_G))
    else $error("parser did not resync after CRC low byte");

  // A CRC failure also counts as a recovery
  a_fail_recovers: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (ev == cfdf_pkg::EV_CRC_FAIL) |=> rec_cnt_r == $past(rec_cnt_r) + 1'b1)
    else $error("recovery count missed a CRC failure");

  // Frame state holds while no item is taken
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(crc_r) && $stable(rcvd_r) && $stable(rec_cnt_r))
    else $error("parser state moved without an item");

endmodule

`default_nettype wire

// ===== hw/rtl/cfdf_out_buf.sv =====
// Result register with a skid stage between the parser and the output channel.
// Takes a new item every cycle while the consumer keeps up. Depends on cfdf_pkg.
`default_nettype none

module cfdf_out_buf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire cfdf_pkg::res_t push_data,
  output logic                push_ready,
  output logic                out_vld,
  input  wire logic           out_rdy,
  output cfdf_pkg::res_t      out_data
);

  logic           out_vld_r, skid_vld_r;
  cfdf_pkg::res_t out_data_r, skid_data_r;
  logic           pop, out_free;

  assign pop        = out_vld_r && out_rdy;
  assign out_free   = pop || !out_vld_r;
  assign push_ready = !skid_vld_r;
  assign out_vld    = out_vld_r;
  assign out_data   = out_data_r;

  // Control: skid drains first into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r  <= skid_vld_r || push;
      skid_vld_r <= skid_vld_r && push;
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_vld_r) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  // Skid only fills behind a held result
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid stage full while output register empty");

  // A held skid item moves forward on a pop
  a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && pop |=> out_vld_r && (out_data_r == $past(skid_data_r)))
    else $error("skid item lost on pop");

  // No item taken while both stages are full
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> !push)
    else $error("item pushed into a full buffer");

endmodule

`default_nettype wire

// ===== hw/rtl/crc16_framed_packet_deframer.sv =====
// Top level of the CRC-16 framed packet deframer.
// Instantiates cfdf_parser and cfdf_out_buf; depends on cfdf_pkg.
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_ready   in_rx_byte
//   out_      output     out_valid / out_ready out_event_res .. out_recoveries
//   cfg_      input      cfg_we (no wait)      cfg_wdata (max payload length)
//
// One byte per cycle while the consumer keeps up; each byte yields one registered result item.
// The parse is one pass through the CRC XOR network and phase decode to the result register.
// A two-entry output buffer (result register plus skid) lets input continue while
// the consumer stalls; in_ready drops only when both entries are full.
// Synchronous active-low reset; max payload length resets to 512.
`default_nettype none

module crc16_framed_packet_deframer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [2:0]                       out_event_res,
  output logic [7:0]                       out_data_byte,
  output logic [7:0]                       out_frame_type,
  output logic [15:0]                      out_frame_length,
  output logic [15:0]                      out_payload_index,
  output logic [15:0]                      out_computed_crc,
  output logic [15:0]                      out_received_crc,
  output logic [cfdf_pkg::CNT_W-1:0]       out_completed_frames,
  output logic [cfdf_pkg::CNT_W-1:0]       out_valid_frames,
  output logic [cfdf_pkg::CNT_W-1:0]       out_crc_failures,
  output logic [cfdf_pkg::CNT_W-1:0]       out_recoveries,
  input  wire logic                        cfg_we,
  input  wire logic [15:0]                 cfg_wdata
);

  logic           accept;
  cfdf_pkg::res_t parse_res, out_res;

  assign accept = in_valid && in_ready;

  cfdf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (parse_res)
  );

  cfdf_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (parse_res),
    .push_ready (in_ready),
    .out_vld    (out_valid),
    .out_rdy    (out_ready),
    .out_data   (out_res)
  );

  // Unpack the result item onto its ports
  assign out_event_res        = out_res.event_res;
  assign out_data_byte        = out_res.data_byte;
  assign out_frame_type       = out_res.frame_type;
  assign out_frame_length     = out_res.frame_length;
  assign out_payload_index    = out_res.payload_index;
  assign out_computed_crc     = out_res.computed_crc;
  assign out_received_crc     = out_res.received_crc;
  assign out_completed_frames = out_res.completed_frames;
  assign out_valid_frames     = out_res.valid_frames;
  assign out_crc_failures     = out_res.crc_failures;
  assign out_recoveries       = out_res.recoveries;

endmodule

`default_nettype wire
